/* design/hpg_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// hpg_pkg
// Shared types, constants and lookup functions for the harmony palette
// generator: word formats, register map, harmony coefficient table.
// ============================================================================
package hpg_pkg;

  localparam int unsigned PALETTE_SIZE = 5;
  localparam int unsigned IdxW         = $clog2(PALETTE_SIZE);
  localparam int unsigned AddrW        = 5;

  // Fixed-point constants.
  localparam logic [15:0] COEF_ONE     = 16'd16384;
  localparam logic [15:0] GAIN_MAX     = 16'd32768;
  localparam logic [14:0] SPREAD_MIN   = 15'd100;
  localparam logic [14:0] SPREAD_MAX   = 15'd18000;
  localparam logic [17:0] HUE_FULL     = 18'd36000;
  localparam logic [17:0] HUE_TWICE    = 18'd72000;
  localparam logic [17:0] HUE_THRICE   = 18'd108000;
  localparam logic [15:0] VALUE_MAX    = 16'd65535;

  // Harmony modes.
  localparam logic [3:0] MODE_ANALOGOUS = 4'd0;
  localparam logic [3:0] MODE_SHADES    = 4'd8;
  localparam logic [3:0] MODE_CUSTOM    = 4'd9;

  // Register indexes.
  localparam logic [2:0] REG_BASE_HUE        = 3'd0;
  localparam logic [2:0] REG_BASE_SATURATION = 3'd1;
  localparam logic [2:0] REG_BASE_LIGHTNESS  = 3'd2;
  localparam logic [2:0] REG_HUE_SPREAD      = 3'd3;
  localparam logic [2:0] REG_HARMONY_MODE    = 3'd4;
  localparam logic [2:0] REG_SATURATION_GAIN = 3'd5;
  localparam logic [2:0] REG_LIGHTNESS_GAIN  = 3'd6;

  // Input operations.
  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_WRITE    = 1'b1;

  typedef struct packed {
    logic        op;
    logic [2:0]  slot;
    logic [15:0] hue_in;
    logic [15:0] saturation_in;
    logic [15:0] lightness_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  color_index;
    logic [15:0] hue_out;
    logic [15:0] saturation_out;
    logic [15:0] lightness_out;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] base_hue;
    logic [15:0] base_saturation;
    logic [15:0] base_lightness;
    logic [14:0] hue_spread;
    logic [3:0]  harmony_mode;
    logic [15:0] saturation_gain;
    logic [15:0] lightness_gain;
  } cfg_t;

  // Multiple of the spread added to the hue.
  typedef enum logic [2:0] {
    SP_NEG2,
    SP_NEG1,
    SP_ZERO,
    SP_HALF,
    SP_POS1,
    SP_POS2
  } spread_e;

  typedef struct packed {
    logic [14:0] hue_add;
    spread_e     spread;
    logic [14:0] s_coef;
    logic [14:0] l_coef;
  } harm_entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_GEN
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic            issue;
    logic [IdxW-1:0] index;
    logic            tbl_write;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic advance;
  } status_t;

  function automatic harm_entry_t mk(input logic [14:0] h, input spread_e s,
                                     input logic [14:0] sc, input logic [14:0] lc);
    harm_entry_t e;
    e.hue_add = h;
    e.spread  = s;
    e.s_coef  = sc;
    e.l_coef  = lc;
    return e;
  endfunction

  // Per-mode hue offsets and saturation/lightness coefficients (Q1.14).
  function automatic harm_entry_t harm_lookup(input logic [2:0] mode,
                                              input logic [IdxW-1:0] k);
    harm_entry_t e;
    e = mk(15'd0, SP_ZERO, 15'd16384, 15'd16384);
    unique case (mode)
      3'd0: begin
        unique case (k)
          3'd0:    e = mk(15'd0, SP_NEG2, 15'd13926, 15'd14746);
          3'd1:    e = mk(15'd0, SP_NEG1, 15'd15565, 15'd15565);
          3'd2:    e = mk(15'd0, SP_ZERO, 15'd16384, 15'd16384);
          3'd3:    e = mk(15'd0, SP_POS1, 15'd15565, 15'd17203);
          default: e = mk(15'd0, SP_POS2, 15'd13926, 15'd18022);
        endcase
      end
      3'd1: begin
        unique case (k)
          3'd0:    e = mk(15'd0, SP_ZERO, 15'd4915,  15'd6554);
          3'd1:    e = mk(15'd0, SP_ZERO, 15'd9830,  15'd10650);
          3'd2:    e = mk(15'd0, SP_ZERO, 15'd16384, 15'd16384);
          3'd3:    e = mk(15'd0, SP_ZERO, 15'd13107, 15'd19661);
          default: e = mk(15'd0, SP_ZERO, 15'd8192,  15'd23757);
        endcase
      end
      3'd2: begin
        unique case (k)
          3'd0:    e = mk(15'd0,     SP_ZERO, 15'd16384, 15'd16384);
          3'd1:    e = mk(15'd12000, SP_ZERO, 15'd14746, 15'd14746);
          3'd2:    e = mk(15'd24000, SP_ZERO, 15'd14746, 15'd14746);
          3'd3:    e = mk(15'd12000, SP_ZERO, 15'd11469, 15'd18842);
          default: e = mk(15'd24000, SP_ZERO, 15'd11469, 15'd18842);
        endcase
      end
      3'd3: begin
        unique case (k)
          3'd0:    e = mk(15'd0,     SP_ZERO, 15'd9830,  15'd8192);
          3'd1:    e = mk(15'd0,     SP_ZERO, 15'd16384, 15'd16384);
          3'd2:    e = mk(15'd0,     SP_ZERO, 15'd11469, 15'd21299);
          3'd3:    e = mk(15'd18000, SP_ZERO, 15'd16384, 15'd16384);
          default: e = mk(15'd18000, SP_ZERO, 15'd11469, 15'd21299);
        endcase
      end
      3'd4: begin
        unique case (k)
          3'd0:    e = mk(15'd0,     SP_ZERO, 15'd16384, 15'd16384);
          3'd1:    e = mk(15'd15000, SP_ZERO, 15'd14746, 15'd14746);
          3'd2:    e = mk(15'd21000, SP_ZERO, 15'd14746, 15'd14746);
          3'd3:    e = mk(15'd15000, SP_ZERO, 15'd10650, 15'd19661);
          default: e = mk(15'd21000, SP_ZERO, 15'd10650, 15'd19661);
        endcase
      end
      3'd5: begin
        unique case (k)
          3'd0:    e = mk(15'd0,     SP_ZERO, 15'd16384, 15'd16384);
          3'd1:    e = mk(15'd0,     SP_POS1, 15'd14746, 15'd15565);
          3'd2:    e = mk(15'd18000, SP_ZERO, 15'd14746, 15'd15565);
          3'd3:    e = mk(15'd18000, SP_POS1, 15'd13926, 15'd17203);
          default: e = mk(15'd0,     SP_HALF, 15'd11469, 15'd19661);
        endcase
      end
      3'd6: begin
        unique case (k)
          3'd0:    e = mk(15'd0,     SP_ZERO, 15'd16384, 15'd16384);
          3'd1:    e = mk(15'd9000,  SP_ZERO, 15'd14746, 15'd14746);
          3'd2:    e = mk(15'd18000, SP_ZERO, 15'd14746, 15'd15565);
          3'd3:    e = mk(15'd27000, SP_ZERO, 15'd14746, 15'd17203);
          default: e = mk(15'd0,     SP_ZERO, 15'd9830,  15'd21299);
        endcase
      end
      default: begin
        unique case (k)
          3'd0:    e = mk(15'd0,     SP_NEG1, 15'd13926, 15'd14746);
          3'd1:    e = mk(15'd0,     SP_ZERO, 15'd16384, 15'd16384);
          3'd2:    e = mk(15'd0,     SP_POS1, 15'd13926, 15'd18022);
          3'd3:    e = mk(15'd18000, SP_ZERO, 15'd12288, 15'd13926);
          default: e = mk(15'd18000, SP_HALF, 15'd9830,  15'd19661);
        endcase
      end
    endcase
    return e;
  endfunction

  // Fixed lightness ramp of the shades mode.
  function automatic logic [15:0] shade_light(input logic [IdxW-1:0] k);
    logic [15:0] v;
    unique case (k)
      3'd0:    v = 16'd58982;
      3'd1:    v = 16'd47185;
      3'd2:    v = 16'd36044;
      3'd3:    v = 16'd24903;
      default: v = 16'd13107;
    endcase
    return v;
  endfunction

endpackage

/* design/harmony_palette_generator_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// harmony_palette_generator_unit
// Builds five-color hue/saturation/lightness palettes from a configured base
// color, spread and harmony mode; also holds a writable custom palette.
// ============================================================================
// Usage:
// The input channel takes one word per accepted cycle (valid high, stall low).
// A generate word (op 0) yields five output words, color_index 0 to 4, with
// last set on the fifth. A write word (op 1) loads one custom table slot and
// yields nothing; slots 5 to 7 are ignored.
// The first color of a palette is taken into the coefficient stage by the
// edge that accepts the generate word, then into the output register; the
// rest follow one per cycle unless the receiver stalls. The sequencer takes
// no new word until five colors are issued; write words go back to back.
// The pipe is a coefficient stage followed by a gain stage and an output
// register; the whole pipe holds while the receiver stalls a waiting word,
// and the input stall rises with it.
// Reset clears the controller, empties the pipe, returns every register to
// its documented default and restores the custom table to hues i*72 degrees.
// Configuration is to be written by the user through the APB-style port only
// while no palette is in flight; the block itself does not enforce this.
// ============================================================================
module harmony_palette_generator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input channel.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  hpg_pkg::in_word_t          in_word_i,
  // Output channel.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output hpg_pkg::out_word_t         out_word_o,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpg_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  hpg_pkg::cfg_t    cfg;
  hpg_pkg::cmd_t    cmd;
  hpg_pkg::status_t status;

  // Register file; values are read straight by the datapath.
  hpg_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The controller issues one color index per cycle while the pipe advances.
  hpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_word_i.op),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath owns the custom table and the output register.
  hpg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* design/hpg_cfg_regs.sv */
`timescale 1ns / 1ps
// ============================================================================
// hpg_cfg_regs
// Configuration register file behind an APB-style slave port.
// ============================================================================
module hpg_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpg_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output hpg_pkg::cfg_t              cfg_o
);

  hpg_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        hpg_pkg::REG_BASE_HUE:        cfg_d.base_hue        = pwdata[15:0];
        hpg_pkg::REG_BASE_SATURATION: cfg_d.base_saturation = pwdata[15:0];
        hpg_pkg::REG_BASE_LIGHTNESS:  cfg_d.base_lightness  = pwdata[15:0];
        hpg_pkg::REG_HUE_SPREAD:      cfg_d.hue_spread      = pwdata[14:0];
        hpg_pkg::REG_HARMONY_MODE:    cfg_d.harmony_mode    = pwdata[3:0];
        hpg_pkg::REG_SATURATION_GAIN: cfg_d.saturation_gain = pwdata[15:0];
        hpg_pkg::REG_LIGHTNESS_GAIN:  cfg_d.lightness_gain  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      hpg_pkg::REG_BASE_HUE:        prdata = {16'd0, cfg_q.base_hue};
      hpg_pkg::REG_BASE_SATURATION: prdata = {16'd0, cfg_q.base_saturation};
      hpg_pkg::REG_BASE_LIGHTNESS:  prdata = {16'd0, cfg_q.base_lightness};
      hpg_pkg::REG_HUE_SPREAD:      prdata = {17'd0, cfg_q.hue_spread};
      hpg_pkg::REG_HARMONY_MODE:    prdata = {28'd0, cfg_q.harmony_mode};
      hpg_pkg::REG_SATURATION_GAIN: prdata = {16'd0, cfg_q.saturation_gain};
      hpg_pkg::REG_LIGHTNESS_GAIN:  prdata = {16'd0, cfg_q.lightness_gain};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_hue        <= 16'd0;
      cfg_q.base_saturation <= 16'd49151;
      cfg_q.base_lightness  <= 16'd42598;
      cfg_q.hue_spread      <= 15'd3000;
      cfg_q.harmony_mode    <= hpg_pkg::MODE_ANALOGOUS;
      cfg_q.saturation_gain <= hpg_pkg::COEF_ONE;
      cfg_q.lightness_gain  <= hpg_pkg::COEF_ONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/hpg_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// hpg_ctrl
// Controller: accepts input words and sequences the five colors of a palette
// into the datapath.
// ============================================================================
module hpg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_stall_o,
  input  hpg_pkg::status_t  status_i,
  output hpg_pkg::cmd_t     cmd_o
);

  localparam logic [hpg_pkg::IdxW-1:0] LastIdx = hpg_pkg::IdxW'(hpg_pkg::PALETTE_SIZE - 1);

  hpg_pkg::state_e              state_q, state_d;
  logic [hpg_pkg::IdxW-1:0]     cnt_q, cnt_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    in_stall_o    = 1'b1;
    cmd_o.issue     = 1'b0;
    cmd_o.index     = cnt_q;
    cmd_o.tbl_write = 1'b0;
    unique case (state_q)
      hpg_pkg::ST_IDLE: begin
        in_stall_o = !status_i.advance;
        if (in_valid_i && status_i.advance) begin
          if (in_op_i == hpg_pkg::OP_WRITE) begin
            cmd_o.tbl_write = 1'b1;
          end else begin
            // The first color leaves in the same cycle the word is taken.
            cmd_o.issue = 1'b1;
            cmd_o.index = '0;
            cnt_d       = hpg_pkg::IdxW'(1);
            state_d     = hpg_pkg::ST_GEN;
          end
        end
      end
      hpg_pkg::ST_GEN: begin
        if (status_i.advance) begin
          cmd_o.issue = 1'b1;
          if (cnt_q == LastIdx) begin
            cnt_d   = '0;
            state_d = hpg_pkg::ST_IDLE;
          end else begin
            cnt_d = cnt_q + hpg_pkg::IdxW'(1);
          end
        end
      end
      default: state_d = hpg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hpg_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* design/hpg_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// hpg_datapath
// Custom color table, coefficient stage, gain and wrap stage and the output
// register. The whole pipe moves together whenever the output slot is free.
// ============================================================================
module hpg_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hpg_pkg::cfg_t       cfg_i,
  input  hpg_pkg::in_word_t   in_word_i,
  input  hpg_pkg::cmd_t       cmd_i,
  output hpg_pkg::status_t    status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hpg_pkg::out_word_t  out_word_o
);

  localparam int unsigned N = hpg_pkg::PALETTE_SIZE;
  localparam logic [hpg_pkg::IdxW-1:0] LastIdx = hpg_pkg::IdxW'(N - 1);

  // Custom color table.
  logic [15:0] cust_hue_q   [N];
  logic [15:0] cust_sat_q   [N];
  logic [15:0] cust_light_q [N];

  logic advance;
  assign advance         = !out_valid_o || !out_stall_i;
  assign status_o.advance = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        cust_hue_q[i]   <= 16'(7200 * i);
        cust_sat_q[i]   <= 16'd49151;
        cust_light_q[i] <= 16'd42598;
      end
    end else if (cmd_i.tbl_write && (in_word_i.slot < 3'(N))) begin
      cust_hue_q[in_word_i.slot]   <= in_word_i.hue_in;
      cust_sat_q[in_word_i.slot]   <= in_word_i.saturation_in;
      cust_light_q[in_word_i.slot] <= in_word_i.lightness_in;
    end
  end

  // ---------------- Stage 1: offsets and mode coefficients -----------------
  logic [14:0]            spread;
  logic [3:0]             mode;
  hpg_pkg::harm_entry_t   entry;
  logic [15:0]            hue_raw, s_x, l_x;
  logic [14:0]            hue_add, s_c, l_c;
  hpg_pkg::spread_e       sp_code;
  logic signed [19:0]     sp_off, hue_sum;
  logic [30:0]            s_prod, l_prod;

  always_comb begin
    if (cfg_i.hue_spread < hpg_pkg::SPREAD_MIN) begin
      spread = hpg_pkg::SPREAD_MIN;
    end else if (cfg_i.hue_spread > hpg_pkg::SPREAD_MAX) begin
      spread = hpg_pkg::SPREAD_MAX;
    end else begin
      spread = cfg_i.hue_spread;
    end
    mode  = (cfg_i.harmony_mode > hpg_pkg::MODE_CUSTOM) ? hpg_pkg::MODE_ANALOGOUS
                                                        : cfg_i.harmony_mode;
    entry = hpg_pkg::harm_lookup(mode[2:0], cmd_i.index);

    if (mode == hpg_pkg::MODE_CUSTOM) begin
      hue_raw = cust_hue_q[cmd_i.index];
      hue_add = '0;
      sp_code = hpg_pkg::SP_ZERO;
      s_x     = cust_sat_q[cmd_i.index];
      s_c     = hpg_pkg::COEF_ONE[14:0];
      l_x     = cust_light_q[cmd_i.index];
      l_c     = hpg_pkg::COEF_ONE[14:0];
    end else if (mode == hpg_pkg::MODE_SHADES) begin
      hue_raw = cfg_i.base_hue;
      hue_add = '0;
      sp_code = hpg_pkg::SP_ZERO;
      s_x     = cfg_i.base_saturation;
      s_c     = hpg_pkg::COEF_ONE[14:0];
      l_x     = hpg_pkg::shade_light(cmd_i.index);
      l_c     = hpg_pkg::COEF_ONE[14:0];
    end else begin
      hue_raw = cfg_i.base_hue;
      hue_add = entry.hue_add;
      sp_code = entry.spread;
      s_x     = cfg_i.base_saturation;
      s_c     = entry.s_coef;
      l_x     = cfg_i.base_lightness;
      l_c     = entry.l_coef;
    end

    unique case (sp_code)
      hpg_pkg::SP_NEG2: sp_off = -$signed({4'd0, spread, 1'b0});
      hpg_pkg::SP_NEG1: sp_off = -$signed({5'd0, spread});
      hpg_pkg::SP_HALF: sp_off = $signed({6'd0, spread[14:1]});
      hpg_pkg::SP_POS1: sp_off = $signed({5'd0, spread});
      hpg_pkg::SP_POS2: sp_off = $signed({4'd0, spread, 1'b0});
      default:          sp_off = '0;
    endcase

    // A full turn is added up front so the sum never goes negative.
    hue_sum = $signed({4'd0, hue_raw}) + $signed({5'd0, hue_add})
            + $signed({2'd0, hpg_pkg::HUE_FULL}) + sp_off;

    s_prod = 31'(s_x) * 31'(s_c);
    l_prod = 31'(l_x) * 31'(l_c);
  end

  logic                     mid_valid_q;
  logic [17:0]              mid_hue_q;
  logic [16:0]              mid_sat_q, mid_light_q;
  logic [hpg_pkg::IdxW-1:0] mid_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (advance) begin
      mid_valid_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mid_hue_q   <= hue_sum[17:0];
      mid_sat_q   <= s_prod[30:14];
      mid_light_q <= l_prod[30:14];
      mid_idx_q   <= cmd_i.index;
    end
  end

  // ---------------- Stage 2: wrap, gains and clamp -------------------------
  logic [17:0] hue_wrap;
  logic [15:0] s_gain, l_gain;
  logic [32:0] s_gprod, l_gprod;
  logic [18:0] s_scaled, l_scaled;
  hpg_pkg::out_word_t out_d;

  always_comb begin
    if (mid_hue_q >= hpg_pkg::HUE_THRICE) begin
      hue_wrap = mid_hue_q - hpg_pkg::HUE_THRICE;
    end else if (mid_hue_q >= hpg_pkg::HUE_TWICE) begin
      hue_wrap = mid_hue_q - hpg_pkg::HUE_TWICE;
    end else if (mid_hue_q >= hpg_pkg::HUE_FULL) begin
      hue_wrap = mid_hue_q - hpg_pkg::HUE_FULL;
    end else begin
      hue_wrap = mid_hue_q;
    end

    s_gain = (cfg_i.saturation_gain > hpg_pkg::GAIN_MAX) ? hpg_pkg::GAIN_MAX
                                                         : cfg_i.saturation_gain;
    l_gain = (cfg_i.lightness_gain > hpg_pkg::GAIN_MAX) ? hpg_pkg::GAIN_MAX
                                                        : cfg_i.lightness_gain;
    s_gprod  = 33'(mid_sat_q) * 33'(s_gain);
    l_gprod  = 33'(mid_light_q) * 33'(l_gain);
    s_scaled = s_gprod[32:14];
    l_scaled = l_gprod[32:14];

    out_d.color_index    = 3'(mid_idx_q);
    out_d.hue_out        = hue_wrap[15:0];
    out_d.saturation_out = (s_scaled > 19'(hpg_pkg::VALUE_MAX)) ? hpg_pkg::VALUE_MAX
                                                                : s_scaled[15:0];
    out_d.lightness_out  = (l_scaled > 19'(hpg_pkg::VALUE_MAX)) ? hpg_pkg::VALUE_MAX
                                                                : l_scaled[15:0];
    out_d.last           = (mid_idx_q == LastIdx);
  end

  logic               out_valid_q;
  hpg_pkg::out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
